/* hdl/hmf_pkg.sv */
package hmf_pkg;

	// Fixed widths of the channel payloads
	localparam int SAMPLE_W     = 8;
	localparam int MODE_COUNT_W = 16;

	// Set tag stored beside each bin count
	localparam int EPOCH_W = 8;

	typedef logic [EPOCH_W-1:0] epoch_t;

	typedef enum logic {
		SWP_CLEAR,
		SWP_RUN
	} sweep_state_t;

	// Status of the clearing sequencer, seen by the bin tracker
	typedef struct packed {
		logic busy;
		logic last_epoch;
	} sweep_stat_t;

endpackage

/* hdl/hmf_if.sv */
interface hmf_in_if import hmf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                last;

	modport source (output valid, sample, last, input ready);
	modport sink   (input valid, sample, last, output ready);
endinterface

interface hmf_out_if import hmf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [SAMPLE_W-1:0]     mode_value;
	logic [MODE_COUNT_W-1:0] mode_count;

	modport source (output valid, mode_value, mode_count, input ready);
	modport sink   (input valid, mode_value, mode_count, output ready);
endinterface

/* hdl/hmf_bin_mem.sv */
module hmf_bin_mem #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 24
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];
	logic [DATA_W-1:0] rd_data_q;

	// Write one entry, read one entry; a read of the entry being written sees the old data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/hmf_sweep.sv */
module hmf_sweep import hmf_pkg::*; #(
	parameter int VALUE_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  set_done,
	output sweep_stat_t           stat,
	output epoch_t                epoch,
	output logic                  clr_en,
	output logic [VALUE_BITS-1:0] clr_addr
);

	sweep_state_t          state_q;
	sweep_state_t          state_d;
	logic [VALUE_BITS-1:0] idx_q;
	epoch_t                epoch_q;

	// Next state: sweep every bin, then run until the set tag wraps
	always_comb begin
		unique case (state_q)
			SWP_CLEAR: state_d = (&idx_q) ? SWP_RUN : SWP_CLEAR;
			SWP_RUN:   state_d = (set_done && (&epoch_q)) ? SWP_CLEAR : SWP_RUN;
			default:   state_d = SWP_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		stat.busy       = (state_q == SWP_CLEAR);
		stat.last_epoch = &epoch_q;
		clr_en          = (state_q == SWP_CLEAR);
	end

	assign clr_addr = idx_q;
	assign epoch    = epoch_q;

	// Advance the sweep index and the set tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SWP_CLEAR;
			idx_q   <= '0;
			epoch_q <= '0;
		end else begin
			state_q <= state_d;
			if (clr_en) begin
				idx_q <= idx_q + 1'b1;
			end
			if (set_done) begin
				epoch_q <= epoch_q + 1'b1;
			end
		end
	end

endmodule

/* hdl/hmf_tracker.sv */
module hmf_tracker import hmf_pkg::*; #(
	parameter int VALUE_BITS = 8,
	parameter int COUNT_BITS = 16,
	localparam int MEM_W     = EPOCH_W + COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hmf_in_if.sink                samples,
	hmf_out_if.source             modes,
	input  sweep_stat_t           stat,
	input  epoch_t                epoch,
	output logic                  rd_en,
	output logic [VALUE_BITS-1:0] rd_addr,
	input  logic [MEM_W-1:0]      rd_data,
	output logic                  wr_en,
	output logic [VALUE_BITS-1:0] wr_addr,
	output logic [MEM_W-1:0]      wr_data,
	output logic                  set_done
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic                  accept;
	logic                  out_free;
	logic                  s1_done;
	logic                  s1_vld_q;
	logic [VALUE_BITS-1:0] idx_s1;
	logic                  last_s1;
	logic                  fwd_vld_q;
	logic [VALUE_BITS-1:0] fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_cnt_q;
	logic [VALUE_BITS-1:0] best_val_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic                  out_vld_q;
	logic [VALUE_BITS-1:0] out_val_q;
	logic [COUNT_BITS-1:0] out_cnt_q;
	epoch_t                rd_tag;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [COUNT_BITS-1:0] cnt_old;
	logic [COUNT_BITS-1:0] cnt_new;
	logic                  better;
	logic [VALUE_BITS-1:0] nxt_val;
	logic [COUNT_BITS-1:0] nxt_cnt;

	// Handshake: a final item waits in s1 until the output register is free;
	// hold off input when the set tag is about to wrap so the sweep starts clean
	always_comb begin
		accept        = samples.valid && samples.ready;
		out_free      = !out_vld_q || modes.ready;
		s1_done       = s1_vld_q && (!last_s1 || out_free);
		samples.ready = !stat.busy
			&& (!s1_vld_q || (s1_done && !(last_s1 && stat.last_epoch)));
	end

	// Issue the bin read at acceptance
	assign rd_en   = accept;
	assign rd_addr = VALUE_BITS'(samples.sample);

	// Count of the bin: forward the last write, drop counts tagged with an older set
	always_comb begin
		rd_tag  = rd_data[MEM_W-1 -: EPOCH_W];
		rd_cnt  = rd_data[COUNT_BITS-1:0];
		if (fwd_vld_q && (fwd_addr_q == idx_s1)) begin
			cnt_old = fwd_cnt_q;
		end else if (rd_tag == epoch) begin
			cnt_old = rd_cnt;
		end else begin
			cnt_old = '0;
		end
		cnt_new = (cnt_old == CNT_MAX) ? cnt_old : cnt_old + 1'b1;
	end

	// Running best: larger count wins, smaller value on a tie
	always_comb begin
		better  = (cnt_new > best_cnt_q)
			|| ((cnt_new == best_cnt_q) && (idx_s1 < best_val_q));
		nxt_val = better ? idx_s1 : best_val_q;
		nxt_cnt = better ? cnt_new : best_cnt_q;
	end

	// Write the bin back
	assign wr_en    = s1_done;
	assign wr_addr  = idx_s1;
	assign wr_data  = {epoch, cnt_new};
	assign set_done = s1_done && last_s1;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q   <= 1'b0;
			fwd_vld_q  <= 1'b0;
			out_vld_q  <= 1'b0;
			best_val_q <= '0;
			best_cnt_q <= '0;
		end else begin
			if (accept) begin
				s1_vld_q <= 1'b1;
			end else if (s1_done) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_done) begin
				fwd_vld_q <= !last_s1;
			end
			if (set_done) begin
				out_vld_q <= 1'b1;
			end else if (modes.ready) begin
				out_vld_q <= 1'b0;
			end
			if (set_done) begin
				best_val_q <= '0;
				best_cnt_q <= '0;
			end else if (s1_done) begin
				best_val_q <= nxt_val;
				best_cnt_q <= nxt_cnt;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1  <= VALUE_BITS'(samples.sample);
			last_s1 <= samples.last;
		end
		if (s1_done) begin
			fwd_addr_q <= idx_s1;
			fwd_cnt_q  <= cnt_new;
		end
		if (set_done) begin
			out_val_q <= nxt_val;
			out_cnt_q <= nxt_cnt;
		end
	end

	assign modes.valid      = out_vld_q;
	assign modes.mode_value = SAMPLE_W'(out_val_q);
	assign modes.mode_count = MODE_COUNT_W'(out_cnt_q);

endmodule

/* hdl/histogram_mode_finder_top.sv */
// Histogram mode finder.
// samples (sink): one value per item in sample, with last set on the final
// value of a set. Only the low VALUE_BITS bits of sample select a bin.
// modes (source): one item per set, the most frequent value of the set and
// its count, smallest value on a tie, count saturating at 2^COUNT_BITS-1.
// Throughput: one item per cycle unless the sweep or a stall holds input.
// Each item reads its bin from the bin memory in the cycle it is accepted
// and writes it back as it leaves s1, so the memory's single read and
// single write port set the rate; a write to the same bin by the item just
// ahead is forwarded. The result is registered as the final item leaves s1.
// Each bin carries a set tag, so a new set starts without clearing the memory.
// Reset: the block sweeps all 2^VALUE_BITS bins, one per cycle, with ready
// low; the same sweep runs after every 256th set.
// Stall: a result waits in the output register while samples go on being
// taken; a further final item waits in the pipeline and then holds input.
module histogram_mode_finder_top import hmf_pkg::*; #(
	parameter int VALUE_BITS = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	hmf_in_if.sink    samples,
	hmf_out_if.source modes
);

	localparam int MEM_W = EPOCH_W + COUNT_BITS;

	sweep_stat_t           stat;
	epoch_t                epoch;
	logic                  clr_en;
	logic [VALUE_BITS-1:0] clr_addr;
	logic                  set_done;
	logic                  rd_en;
	logic [VALUE_BITS-1:0] rd_addr;
	logic [MEM_W-1:0]      rd_data;
	logic                  trk_wr_en;
	logic [VALUE_BITS-1:0] trk_wr_addr;
	logic [MEM_W-1:0]      trk_wr_data;
	logic                  mem_wr_en;
	logic [VALUE_BITS-1:0] mem_wr_addr;
	logic [MEM_W-1:0]      mem_wr_data;

	hmf_sweep #(
		.VALUE_BITS(VALUE_BITS)
	) u_sweep (
		.clk      (clk),
		.arst_n   (arst_n),
		.set_done (set_done),
		.stat     (stat),
		.epoch    (epoch),
		.clr_en   (clr_en),
		.clr_addr (clr_addr)
	);

	hmf_tracker #(
		.VALUE_BITS(VALUE_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.modes    (modes),
		.stat     (stat),
		.epoch    (epoch),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (trk_wr_en),
		.wr_addr  (trk_wr_addr),
		.wr_data  (trk_wr_data),
		.set_done (set_done)
	);

	// Select the sweep or the bin update onto the write port
	always_comb begin
		mem_wr_en   = clr_en || trk_wr_en;
		mem_wr_addr = clr_en ? clr_addr : trk_wr_addr;
		mem_wr_data = clr_en ? {epoch, {COUNT_BITS{1'b0}}} : trk_wr_data;
	end

	hmf_bin_mem #(
		.ADDR_W(VALUE_BITS),
		.DATA_W(MEM_W)
	) u_bin_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

endmodule

/* hdl/hmf_checker.sv */
module hmf_checker import hmf_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    in_last,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [SAMPLE_W-1:0]     mode_value,
	input logic [MODE_COUNT_W-1:0] mode_count
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mode_value) && $stable(mode_count))
		else $error("result changed while stalled");

	// A final item behind a stalled result holds input until the result is taken
	a_final_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last && out_valid && !out_ready
		|=> !in_ready || out_ready)
		else $error("input taken while a final item waits behind a stalled result");

	// Leaving reset, the bin sweep holds input off
	a_reset_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready)
		else $error("input ready during the reset sweep");

	// Leaving reset, no result is shown
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result shown right after reset");

endmodule

bind histogram_mode_finder_top hmf_checker u_hmf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.in_last    (samples.last),
	.out_valid  (modes.valid),
	.out_ready  (modes.ready),
	.mode_value (modes.mode_value),
	.mode_count (modes.mode_count)
);
